// ===== rtl/sbsf_pkg.sv =====
// sbsf_pkg: shared widths, register codes, reset values and types of the
// stereo biquad shelf filter. Used by the interfaces, the datapath and the top level.
// No dependencies.
package sbsf_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned STATE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned COEF_FRAC_BITS_DEF  = 20;
  localparam int unsigned STATE_FRAC_BITS_DEF = 8;

  // register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_ENABLE = 3'd0,
    REG_COEF_B0       = 3'd1,
    REG_COEF_B1       = 3'd2,
    REG_COEF_B2       = 3'd3,
    REG_COEF_A1       = 3'd4,
    REG_COEF_A2       = 3'd5
  } cfg_reg_e;

  // reset coefficients: unity gain straight through
  localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd1048576;
  localparam logic signed [COEF_W-1:0] COEF_ZERO   = '0;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [STATE_W-1:0]  state_t;

  // register file contents handed to both channel datapaths
  typedef struct packed {
    logic  enable;
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coefs_t;

endpackage

// ===== rtl/sbsf_ifs.sv =====
// sbsf_ifs: handshake interfaces of the stereo biquad shelf filter
// (frame input, result output, configuration writes).
// Depends on sbsf_pkg.
interface sbsf_frame_if;
  logic              valid;
  logic              ready;
  sbsf_pkg::sample_t left_in;
  sbsf_pkg::sample_t right_in;
  logic              frame_last;

  modport source (output valid, left_in, right_in, frame_last, input ready);
  modport sink   (input valid, left_in, right_in, frame_last, output ready);
endinterface

interface sbsf_result_if;
  logic              valid;
  logic              ready;
  sbsf_pkg::sample_t left_out;
  sbsf_pkg::sample_t right_out;
  logic              frame_last_out;

  modport source (output valid, left_out, right_out, frame_last_out, input ready);
  modport sink   (input valid, left_out, right_out, frame_last_out, output ready);
endinterface

interface sbsf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sbsf_pkg::CFG_IDX_W-1:0]      index;
  logic [sbsf_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sbsf_regs.sv =====
// sbsf_regs: configuration register file (enable and five Q3.20 coefficients).
// Depends on sbsf_pkg.
module sbsf_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [sbsf_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [sbsf_pkg::CFG_DATA_W-1:0] wr_data_i,
  output sbsf_pkg::coefs_t                coefs_o
);

  sbsf_pkg::coefs_t coefs_q, coefs_d;

  always_comb begin
    coefs_d = coefs_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        sbsf_pkg::REG_FILTER_ENABLE: coefs_d.enable = wr_data_i[0];
        sbsf_pkg::REG_COEF_B0:       coefs_d.b0     = sbsf_pkg::coef_t'(wr_data_i);
        sbsf_pkg::REG_COEF_B1:       coefs_d.b1     = sbsf_pkg::coef_t'(wr_data_i);
        sbsf_pkg::REG_COEF_B2:       coefs_d.b2     = sbsf_pkg::coef_t'(wr_data_i);
        sbsf_pkg::REG_COEF_A1:       coefs_d.a1     = sbsf_pkg::coef_t'(wr_data_i);
        sbsf_pkg::REG_COEF_A2:       coefs_d.a2     = sbsf_pkg::coef_t'(wr_data_i);
        default:                     coefs_d        = coefs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q.enable <= 1'b0;
      coefs_q.b0     <= sbsf_pkg::COEF_B0_RST;
      coefs_q.b1     <= sbsf_pkg::COEF_ZERO;
      coefs_q.b2     <= sbsf_pkg::COEF_ZERO;
      coefs_q.a1     <= sbsf_pkg::COEF_ZERO;
      coefs_q.a2     <= sbsf_pkg::COEF_ZERO;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  assign coefs_o = coefs_q;

endmodule

// ===== rtl/sbsf_biquad.sv =====
// sbsf_biquad: one channel of the direct-form-I biquad, its history
// registers and the pass-through select. Depends on sbsf_pkg.
module sbsf_biquad #(
  parameter int unsigned COEF_FRAC_BITS  = sbsf_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned STATE_FRAC_BITS = sbsf_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbsf_pkg::coefs_t  coefs_i,
  input  sbsf_pkg::sample_t x_i,
  input  logic              step_i,
  output sbsf_pkg::sample_t y_o
);

  localparam int unsigned PFF_W = sbsf_pkg::COEF_W + sbsf_pkg::SAMPLE_W;
  localparam int unsigned PFB_W = sbsf_pkg::COEF_W + sbsf_pkg::STATE_W;
  localparam int unsigned FF_W  = PFF_W + 2;
  localparam int unsigned ACC_W =
    ((FF_W + STATE_FRAC_BITS > PFB_W) ? FF_W + STATE_FRAC_BITS : PFB_W) + 2;
  localparam int unsigned O_W   = sbsf_pkg::STATE_W + 1;

  localparam logic signed [ACC_W-1:0] CMASK   = ACC_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
  localparam logic signed [O_W-1:0]   SMASK   = O_W'((64'sd1 <<< STATE_FRAC_BITS) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ST_MAX  = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] ST_MIN  = ACC_W'(-64'sd2147483648);
  localparam logic signed [O_W-1:0]   OUT_MAX = O_W'(64'sd32767);
  localparam logic signed [O_W-1:0]   OUT_MIN = O_W'(-64'sd32768);

  sbsf_pkg::sample_t in_d1_q, in_d2_q;
  sbsf_pkg::state_t  out_d1_q, out_d2_q;

  logic signed [PFF_W-1:0] p_b0, p_b1, p_b2;
  logic signed [PFB_W-1:0] p_a1, p_a2;
  logic signed [ACC_W-1:0] ff, acc, acc_tz, y_wide;
  sbsf_pkg::state_t        y_sat;
  logic signed [O_W-1:0]   y_ext, y_tz, o_wide;
  sbsf_pkg::sample_t       o_sat;

  assign p_b0 = $signed(coefs_i.b0) * x_i;
  assign p_b1 = $signed(coefs_i.b1) * in_d1_q;
  assign p_b2 = $signed(coefs_i.b2) * in_d2_q;
  assign p_a1 = $signed(coefs_i.a1) * out_d1_q;
  assign p_a2 = $signed(coefs_i.a2) * out_d2_q;

  always_comb begin
    ff     = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2);
    acc    = (ff <<< STATE_FRAC_BITS) - ACC_W'(p_a1) - ACC_W'(p_a2);
    // truncate toward zero: bias negative sums before the arithmetic shift
    acc_tz = acc + (acc[ACC_W-1] ? CMASK : '0);
    y_wide = acc_tz >>> COEF_FRAC_BITS;
    if (y_wide > ST_MAX) begin
      y_sat = sbsf_pkg::STATE_W'(ST_MAX);
    end else if (y_wide < ST_MIN) begin
      y_sat = sbsf_pkg::STATE_W'(ST_MIN);
    end else begin
      y_sat = sbsf_pkg::STATE_W'(y_wide);
    end

    y_ext  = O_W'(y_sat);
    y_tz   = y_ext + (y_ext[O_W-1] ? SMASK : '0);
    o_wide = y_tz >>> STATE_FRAC_BITS;
    if (o_wide > OUT_MAX) begin
      o_sat = sbsf_pkg::SAMPLE_W'(OUT_MAX);
    end else if (o_wide < OUT_MIN) begin
      o_sat = sbsf_pkg::SAMPLE_W'(OUT_MIN);
    end else begin
      o_sat = sbsf_pkg::SAMPLE_W'(o_wide);
    end
  end

  assign y_o = coefs_i.enable ? o_sat : x_i;

  // history only moves while filtering
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_d1_q  <= '0;
      in_d2_q  <= '0;
      out_d1_q <= '0;
      out_d2_q <= '0;
    end else if (step_i && coefs_i.enable) begin
      in_d1_q  <= x_i;
      in_d2_q  <= in_d1_q;
      out_d1_q <= y_sat;
      out_d2_q <= out_d1_q;
    end
  end

endmodule

// ===== rtl/stereo_biquad_shelf_filter.sv =====
// stereo_biquad_shelf_filter: top level, input register, two channel
// datapaths, result register. Depends on sbsf_pkg, sbsf_ifs, sbsf_regs, sbsf_biquad.
//
//   channel    | modport         | payload                              | moves
//   -----------+-----------------+--------------------------------------+-------------------
//   cfg_i      | sbsf_cfg_if     | index[2:0], data[23:0]               | one register write
//   frame_i    | sbsf_frame_if   | left_in, right_in, frame_last        | one stereo item
//   result_o   | sbsf_result_if  | left_out, right_out, frame_last_out  | one filtered item
//
// one item per cycle sustained while result_o is not stalled; a result shows once its item
// has passed the input register, then the multiply-accumulate of sbsf_biquad into the result register
// the feedback recurrence is combinational from the history registers through the five products of each channel
// reset clears handshake state and history; coefficients return to unity pass-through
// a stalled result holds in the result register while one more item waits in the
// input register; the configuration channel is always ready
module stereo_biquad_shelf_filter #(
  parameter int unsigned COEF_FRAC_BITS  = sbsf_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned STATE_FRAC_BITS = sbsf_pkg::STATE_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbsf_cfg_if.sink    cfg_i,
  sbsf_frame_if.sink  frame_i,
  sbsf_result_if.source result_o
);

  sbsf_pkg::coefs_t coefs;

  // input register
  logic              s1_valid_q, s1_valid_d;
  sbsf_pkg::sample_t s1_left_q, s1_right_q;
  logic              s1_last_q;

  // result register
  logic              out_valid_q, out_valid_d;
  sbsf_pkg::sample_t out_left_q, out_right_q;
  logic              out_last_q;

  sbsf_pkg::sample_t left_y, right_y;
  logic              advance, in_take;

  // config writes are never stalled
  assign cfg_i.ready = 1'b1;

  sbsf_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .coefs_o   (coefs)
  );

  // item leaves the input register when the result register is free or emptying
  assign advance       = s1_valid_q && (!out_valid_q || result_o.ready);
  assign frame_i.ready = !s1_valid_q || advance;
  assign in_take       = frame_i.valid && frame_i.ready;

  assign s1_valid_d  = in_take || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_left_q  <= frame_i.left_in;
      s1_right_q <= frame_i.right_in;
      s1_last_q  <= frame_i.frame_last;
    end
    if (advance) begin
      out_left_q  <= left_y;
      out_right_q <= right_y;
      out_last_q  <= s1_last_q;
    end
  end

  // channel datapaths; history steps, while filtering, as the item moves into the result register
  sbsf_biquad #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coefs_i (coefs),
    .x_i     (s1_left_q),
    .step_i  (advance),
    .y_o     (left_y)
  );

  sbsf_biquad #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coefs_i (coefs),
    .x_i     (s1_right_q),
    .step_i  (advance),
    .y_o     (right_y)
  );

  assign result_o.valid          = out_valid_q;
  assign result_o.left_out       = out_left_q;
  assign result_o.right_out      = out_right_q;
  assign result_o.frame_last_out = out_last_q;

endmodule

// ===== rtl/sbsf_checker.sv =====
// sbsf_checker: port-level checks of the stereo biquad shelf filter, bound
// to the top level. Depends on sbsf_pkg and stereo_biquad_shelf_filter.
module sbsf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              frame_valid_i,
  input logic              frame_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input sbsf_pkg::sample_t res_left_i,
  input sbsf_pkg::sample_t res_right_i,
  input logic              res_last_i
);

  // nothing is shown while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !res_valid_i)
    else $error("result valid during reset");

  // an empty result register always leaves room for a new item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> frame_ready_i)
    else $error("input stalled with result register empty");

  // a taken item passes the input register and reaches the result register when the output side does not stall
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_i && frame_ready_i) ##1 (!res_valid_i || res_ready_i) |=> res_valid_i)
    else $error("item did not reach the result register in two cycles");

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_left_i)
      && $stable(res_right_i) && $stable(res_last_i))
    else $error("stalled result changed");

endmodule

bind stereo_biquad_shelf_filter sbsf_checker u_sbsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frame_valid_i (frame_i.valid),
  .frame_ready_i (frame_i.ready),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_left_i    (result_o.left_out),
  .res_right_i   (result_o.right_out),
  .res_last_i    (result_o.frame_last_out)
);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for stereo_biquad_shelf_filter, driving stereo items
// under many coefficient settings with random gaps and stalls on both channels
// depends on sbsf_pkg, sbsf_ifs and the rtl top level
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sbsf_pkg::*;

  localparam int unsigned CLK_HALF        = 5;
  localparam int unsigned COEF_FRAC       = COEF_FRAC_BITS_DEF;
  localparam int unsigned STATE_FRAC      = STATE_FRAC_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS    = 1780;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned SETTLE_CYCLES   = 10;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam coef_t   COEF_MAX   = 24'sh7fffff;
  localparam coef_t   COEF_MIN   = 24'sh800000;

  // feedback state saturation bounds
  localparam longint STATE_HI = (longint'(1) << (STATE_W - 1)) - 1;
  localparam longint STATE_LO = -(longint'(1) << (STATE_W - 1));

  // history of one channel: last two inputs, last two state-saturated outputs before the output clamp
  typedef struct {
    sample_t x_d1;
    sample_t x_d2;
    state_t  y_d1;
    state_t  y_d2;
  } biquad_hist_t;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    last;
  } frame_t;

  // tracks the filter's registers and history and holds the awaited results
  class shelf_tracker;
    logic         enable;
    coef_t        b0, b1, b2, a1, a2;
    biquad_hist_t hist [2];
    frame_t       awaited [$];
    int unsigned  mismatches;

    function new();
      enable = 1'b0;
      b0 = COEF_B0_RST;
      b1 = COEF_ZERO;
      b2 = COEF_ZERO;
      a1 = COEF_ZERO;
      a2 = COEF_ZERO;
      mismatches = 0;
      for (int c = 0; c < 2; c++) begin
        hist[c].x_d1 = '0;
        hist[c].x_d2 = '0;
        hist[c].y_d1 = '0;
        hist[c].y_d2 = '0;
      end
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FILTER_ENABLE: enable = data[0];
        REG_COEF_B0:       b0 = coef_t'(data);
        REG_COEF_B1:       b1 = coef_t'(data);
        REG_COEF_B2:       b2 = coef_t'(data);
        REG_COEF_A1:       a1 = coef_t'(data);
        REG_COEF_A2:       a2 = coef_t'(data);
        default: ;
      endcase
    endfunction

    // one direct-form-i step of channel ch
    function sample_t filter_sample(int unsigned ch, sample_t x);
      longint ff, acc, y, o;
      ff = longint'(b0) * longint'(x)
         + longint'(b1) * longint'(hist[ch].x_d1)
         + longint'(b2) * longint'(hist[ch].x_d2);
      acc = ff * (longint'(1) << STATE_FRAC)
          - longint'(a1) * longint'(hist[ch].y_d1)
          - longint'(a2) * longint'(hist[ch].y_d2);
      // signed division truncates toward zero
      y = acc / (longint'(1) << COEF_FRAC);
      if (y > STATE_HI) y = STATE_HI;
      if (y < STATE_LO) y = STATE_LO;
      hist[ch].x_d2 = hist[ch].x_d1;
      hist[ch].x_d1 = x;
      hist[ch].y_d2 = hist[ch].y_d1;
      hist[ch].y_d1 = state_t'(y);
      o = y / (longint'(1) << STATE_FRAC);
      if (o > longint'(SAMPLE_MAX)) o = longint'(SAMPLE_MAX);
      if (o < longint'(SAMPLE_MIN)) o = longint'(SAMPLE_MIN);
      return sample_t'(o);
    endfunction

    function void note_frame(sample_t l, sample_t r, logic last);
      frame_t e;
      e.left  = enable ? filter_sample(0, l) : l;
      e.right = enable ? filter_sample(1, r) : r;
      e.last  = last;
      awaited.push_back(e);
    endfunction

    function void check_result(sample_t l, sample_t r, logic last);
      frame_t e;
      if (awaited.size() == 0) begin
        $error("result with no item awaited: left_out %0d right_out %0d", l, r);
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      if (l !== e.left) begin
        $error("left_out: expected %0d, got %0d", e.left, l);
        mismatches++;
      end
      if (r !== e.right) begin
        $error("right_out: expected %0d, got %0d", e.right, r);
        mismatches++;
      end
      if (last !== e.last) begin
        $error("frame_last_out: expected %0b, got %0b", e.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  sbsf_frame_if  frm ();
  sbsf_result_if res ();
  sbsf_cfg_if    cfg ();

  stereo_biquad_shelf_filter dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .frame_i  (frm),
    .result_o (res)
  );

  shelf_tracker tracker = new();

  // idling control shared by the sender, the receiver, the main flow, the monitor and the watchdog
  bit          tx_steady;
  bit          rx_steady;
  bit          hold_off_req;
  int unsigned quiet_cycles;

  always #CLK_HALF clk_i = ~clk_i;

  // gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  // sample mix: full-scale extremes, quiet audio, anything
  function automatic sample_t pick_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (roll < 40) return sample_t'(int'($urandom_range(0, 1000)) - 500);
    return sample_t'($urandom());
  endfunction

  function automatic coef_t pick_extreme();
    case ($urandom_range(0, 2))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: return COEF_ZERO;
    endcase
  endfunction

  // one filter setting: mostly stable shelves, some wild or extreme, some bypass
  function automatic coefs_t pick_setting();
    coefs_t s;
    int unsigned roll;
    int a1v, a2v, lim;
    roll = $urandom_range(0, 99);
    // poles inside the unit circle: |a2| < 1 and |a1| < 1 + a2
    a2v = int'($urandom_range(0, 2040000)) - 1000000;
    lim = 1048576 + a2v - 2000;
    a1v = int'($urandom_range(0, lim));
    if ($urandom_range(0, 1)) a1v = -a1v;
    s.enable = 1'b1;
    s.b0 = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
    s.b1 = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
    s.b2 = coef_t'(int'($urandom_range(0, 4194304)) - 2097152);
    s.a1 = coef_t'(a1v);
    s.a2 = coef_t'(a2v);
    if (roll >= 60 && roll < 75) begin
      s.b0 = coef_t'($urandom());
      s.b1 = coef_t'($urandom());
      s.b2 = coef_t'($urandom());
      s.a1 = coef_t'($urandom());
      s.a2 = coef_t'($urandom());
    end else if (roll >= 75 && roll < 87) begin
      s.b0 = pick_extreme();
      s.b1 = pick_extreme();
      s.b2 = pick_extreme();
      s.a1 = pick_extreme();
      s.a2 = pick_extreme();
    end else if (roll >= 87) begin
      s.enable = 1'b0;
    end
    return s;
  endfunction

  // one register write, held until the channel takes it
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  // full setting, enable word padded with junk above bit 0, sometimes a spare write
  task automatic apply_setting(coefs_t s, logic [CFG_DATA_W-2:0] pad);
    program_reg(REG_FILTER_ENABLE, {pad, s.enable});
    program_reg(REG_COEF_B0, s.b0);
    program_reg(REG_COEF_B1, s.b1);
    program_reg(REG_COEF_B2, s.b2);
    program_reg(REG_COEF_A1, s.a1);
    program_reg(REG_COEF_A2, s.a2);
    if ($urandom_range(0, 4) == 0)
      program_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 24'($urandom()));
    cfg.valid <= 1'b0;
  endtask

  // offer one item after a random gap; valid stays high into the next item when no gap
  task automatic send_frame(sample_t l, sample_t r, logic last);
    int unsigned gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      frm.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frm.valid      <= 1'b1;
    frm.left_in    <= l;
    frm.right_in   <= r;
    frm.frame_last <= last;
    @(posedge clk_i);
    while (!frm.ready) @(posedge clk_i);
  endtask

  // stop offering and wait until every awaited result is in, so the block is idle
  task automatic settle();
    frm.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // watch all three channels at the clock edge, before any new drive lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready)
        tracker.check_result(res.left_out, res.right_out, res.frame_last_out);
      if (frm.valid && frm.ready)
        tracker.note_frame(frm.left_in, frm.right_in, frm.frame_last);
      if (cfg.valid && cfg.ready)
        tracker.apply_reg(cfg.index, cfg.data);
      if ((res.valid && res.ready) || (frm.valid && frm.ready) || (cfg.valid && cfg.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned gap;
    stall_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        gap = pick_gap(rx_steady);
        if (gap == 0) begin
          res.ready <= 1'b1;
        end else begin
          res.ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  // main flow: reset, directed cases, then random phases
  initial begin
    coefs_t      s;
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    quiet_cycles = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    hold_off_req = 1'b0;
    rst_ni         <= 1'b0;
    frm.valid      <= 1'b0;
    frm.left_in    <= '0;
    frm.right_in   <= '0;
    frm.frame_last <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= '0;
    cfg.data       <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // straight after reset: bypass, extremes and both marker values
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_frame('0, -16'sd1, 1'b1);
    send_frame(16'sd1, '0, 1'b0);
    settle();

    // filter on with reset coefficients, should be unity gain
    program_reg(REG_FILTER_ENABLE, 24'd1);
    cfg.valid <= 1'b0;
    send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_frame(16'sd12345, -16'sd2, 1'b0);
    settle();

    // spare indexes are dropped, enable looks at bit 0 only; bypass keeps history
    program_reg(REG_SPARE_6, 24'hffffff);
    program_reg(REG_SPARE_7, 24'h5a5a5a);
    program_reg(REG_FILTER_ENABLE, 24'hfffffe);
    cfg.valid <= 1'b0;
    send_frame(-16'sd300, 16'sd7, 1'b1);
    send_frame(16'sd4096, SAMPLE_MIN, 1'b0);
    settle();
    program_reg(REG_FILTER_ENABLE, 24'h000001);
    program_reg(REG_COEF_B1, 24'h080000);
    cfg.valid <= 1'b0;
    send_frame(16'sd1000, -16'sd1000, 1'b0);
    send_frame(16'sd2, 16'sd3, 1'b1);
    settle();

    // runaway feedback: state saturates high, then the other way
    s.enable = 1'b1;
    s.b0 = COEF_MAX;
    s.b1 = COEF_MAX;
    s.b2 = COEF_MAX;
    s.a1 = COEF_MIN;
    s.a2 = COEF_MIN;
    apply_setting(s, '0);
    repeat (5) send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    settle();
    s.b0 = COEF_MIN;
    s.b1 = COEF_MIN;
    s.b2 = COEF_MIN;
    s.a1 = COEF_MAX;
    apply_setting(s, '1);
    repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    settle();

    // random phases, each under a fresh setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      apply_setting(pick_setting(), 23'($urandom()));
      tx_steady = (phase % 5 == 4);
      rx_steady = tx_steady;
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering, so the block backs up
        tx_steady    = 1'b1;
        hold_off_req = 1'b1;
      end
      n = $urandom_range(40, 200);
      // last phase trimmed to the item budget
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) send_frame(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
      sent += n;
      phase++;
      settle();
    end

    // quiet tail so a stray extra result would still be seen
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
